// File: src/mcrt_pkg.sv
// Shared types and constants for the multi-channel reload timer.
package mcrt_pkg;

	localparam int FUNC_W   = 3;
	localparam int SEL_W    = 3;
	localparam int PRE_W    = 16;
	localparam int PER_W    = 32;
	localparam int STEP_W   = 24;
	localparam int TIME_W   = 48;
	localparam int COUNT_W  = 32;
	localparam int DIV_W    = 48;
	localparam int DCNT_W   = 6;

	localparam logic [STEP_W-1:0] TICK_STEP_RST = 24'd1000;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK       = 3'd0,
		FN_INIT       = 3'd1,
		FN_SET_PERIOD = 3'd2,
		FN_START      = 3'd3,
		FN_READ_COUNT = 3'd4,
		FN_READ_PEND  = 3'd5
	} func_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_MUL,
		OP_INIT,
		OP_SHADOW,
		OP_START,
		OP_PEND,
		OP_CNT_START,
		OP_CNT_WRITE,
		OP_TICK_ADD,
		OP_SETTLE,
		OP_MOD_START,
		OP_MOD_WRITE
	} dp_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WRITE,
		S_TADD,
		S_TSETTLE,
		S_TDIV,
		S_CWAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   idx_clr;
		logic   idx_inc;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  sel_ok;
		logic  running;
		logic  expire;
		logic  zero_per;
		logic  rem_lt;
		logic  idx_last;
		logic  div_done;
		logic  out_free;
	} dp_sts_t;

endpackage

// File: src/mcrt_in_if.sv
// Request channel: valid/ready handshake carrying one timer operation.
interface mcrt_in_if;
	logic                         valid;
	logic                         ready;
	logic [mcrt_pkg::FUNC_W-1:0]  func;
	logic [mcrt_pkg::SEL_W-1:0]   timer_sel;
	logic [mcrt_pkg::PRE_W-1:0]   prescale;
	logic [mcrt_pkg::PER_W-1:0]   period_value;

	modport source (output valid, func, timer_sel, prescale, period_value, input ready);
	modport sink (input valid, func, timer_sel, prescale, period_value, output ready);
endinterface

// File: src/mcrt_out_if.sv
// Result channel: valid/ready handshake carrying one operation result.
interface mcrt_out_if;
	logic                          valid;
	logic                          ready;
	logic [mcrt_pkg::COUNT_W-1:0]  count_value;
	logic                          pending_flag;

	modport source (output valid, count_value, pending_flag, input ready);
	modport sink (input valid, count_value, pending_flag, output ready);
endinterface

// File: src/mcrt_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module mcrt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mcrt_pkg::DIV_W-1:0]  dividend,
	input  logic [mcrt_pkg::DIV_W-1:0]  divisor,
	output logic                        done,
	output logic [mcrt_pkg::DIV_W-1:0]  quotient,
	output logic [mcrt_pkg::DIV_W-1:0]  remainder
);

	localparam int W = mcrt_pkg::DIV_W;

	logic              busy_q;
	logic              done_q;
	logic [mcrt_pkg::DCNT_W-1:0] cnt_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic [W-1:0]      dsr_q;

	logic [W:0]        shifted;
	logic [W:0]        trial;
	logic              fits;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		trial   = shifted - {1'b0, dsr_q};
		fits    = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mcrt_pkg::DCNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the difference fits W bits
			rem_q <= fits ? trial[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_no_restart : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

endmodule

// File: src/mcrt_datapath.sv
// Timer state, scaling multiplier, tick arithmetic, divider and result registers.
module mcrt_datapath #(
	parameter int NUM_TIMERS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mcrt_pkg::STEP_W-1:0]   cfg_wr_data,
	input  logic [mcrt_pkg::FUNC_W-1:0]   in_func,
	input  logic [mcrt_pkg::SEL_W-1:0]    in_timer_sel,
	input  logic [mcrt_pkg::PRE_W-1:0]    in_prescale,
	input  logic [mcrt_pkg::PER_W-1:0]    in_period_value,
	input  mcrt_pkg::dp_cmd_t             cmd,
	output mcrt_pkg::dp_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mcrt_pkg::COUNT_W-1:0]  out_count_value,
	output logic                          out_pending_flag
);

	localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int TW     = mcrt_pkg::TIME_W;
	localparam int DW     = mcrt_pkg::PRE_W;

	// per-timer state
	logic [mcrt_pkg::STEP_W-1:0] step_q;
	logic [TW-1:0]               active_q  [NUM_TIMERS];
	logic [TW-1:0]               shadow_q  [NUM_TIMERS];
	logic [TW-1:0]               elapsed_q [NUM_TIMERS];
	logic [DW-1:0]               div_q     [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]       run_q;
	logic [NUM_TIMERS-1:0]       pend_q;
	logic [TIDX_W-1:0]           idx_q;

	// captured request and work registers
	logic [mcrt_pkg::FUNC_W-1:0] func_q;
	logic [mcrt_pkg::SEL_W-1:0]  sel_q;
	logic [mcrt_pkg::PRE_W-1:0]  pre_q;
	logic [mcrt_pkg::PER_W-1:0]  per_q;
	logic [TW-1:0]               acc_q;
	logic [TW-1:0]               prod_q;
	logic [mcrt_pkg::COUNT_W-1:0] res_count_q;
	logic                        res_pend_q;
	logic                        out_valid_q;
	logic [mcrt_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_pend_q;

	logic [TW-1:0]               cur_active;
	logic [TW-1:0]               cur_shadow;
	logic [TW-1:0]               cur_elapsed;
	logic [DW-1:0]               cur_div;
	logic [DW-1:0]               eff_pre;
	logic [DW-1:0]               eff_cur;
	logic [DW-1:0]               mul_div;
	logic [mcrt_pkg::PER_W:0]    per_p1;
	logic [TW:0]                 prod_full;
	logic [TW:0]                 sum;
	logic [TW:0]                 diff;
	logic                        ge;

	logic                        div_start;
	logic [mcrt_pkg::DIV_W-1:0]  div_dividend;
	logic [mcrt_pkg::DIV_W-1:0]  div_divisor;
	logic                        div_done;
	logic [mcrt_pkg::DIV_W-1:0]  div_quo;
	logic [mcrt_pkg::DIV_W-1:0]  div_rem;

	always_comb begin
		cur_active  = active_q[idx_q];
		cur_shadow  = shadow_q[idx_q];
		cur_elapsed = elapsed_q[idx_q];
		cur_div     = div_q[idx_q];
		eff_pre     = (pre_q == '0) ? DW'(1) : pre_q;
		eff_cur     = (cur_div == '0) ? DW'(1) : cur_div;
		mul_div     = (func_q == mcrt_pkg::FN_INIT) ? eff_pre : eff_cur;
		per_p1      = {1'b0, per_q} + (mcrt_pkg::PER_W + 1)'(1);
		prod_full   = (TW + 1)'(per_p1) * (TW + 1)'(mul_div);
		sum         = {1'b0, cur_elapsed} + (TW + 1)'(step_q);
		ge          = sum >= {1'b0, cur_active};
		diff        = sum - {1'b0, cur_active};
	end

	always_comb begin
		div_start    = (cmd.op == mcrt_pkg::OP_MOD_START) || (cmd.op == mcrt_pkg::OP_CNT_START);
		div_dividend = (cmd.op == mcrt_pkg::OP_CNT_START) ? cur_elapsed : acc_q;
		div_divisor  = (cmd.op == mcrt_pkg::OP_CNT_START) ? mcrt_pkg::DIV_W'(eff_cur)
		                                                   : cur_active;
	end

	mcrt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		sts.func     = mcrt_pkg::func_t'(func_q);
		sts.sel_ok   = int'(sel_q) < NUM_TIMERS;
		sts.running  = run_q[idx_q];
		sts.expire   = ge;
		sts.zero_per = cur_active == '0;
		sts.rem_lt   = acc_q < cur_active;
		sts.idx_last = idx_q == TIDX_W'(NUM_TIMERS - 1);
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= mcrt_pkg::TICK_STEP_RST;
			run_q       <= '0;
			pend_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				active_q[i]  <= '0;
				shadow_q[i]  <= '0;
				elapsed_q[i] <= '0;
				div_q[i]     <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				step_q <= cfg_wr_data;
			end
			if (cmd.op == mcrt_pkg::OP_CAPTURE) begin
				idx_q <= TIDX_W'(in_timer_sel);
			end else if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			case (cmd.op)
				mcrt_pkg::OP_INIT: begin
					run_q[idx_q]     <= 1'b0;
					pend_q[idx_q]    <= 1'b0;
					elapsed_q[idx_q] <= '0;
					div_q[idx_q]     <= eff_pre;
					active_q[idx_q]  <= prod_q;
					shadow_q[idx_q]  <= prod_q;
				end
				mcrt_pkg::OP_SHADOW: begin
					shadow_q[idx_q] <= prod_q;
				end
				mcrt_pkg::OP_START: begin
					active_q[idx_q]  <= cur_shadow;
					elapsed_q[idx_q] <= '0;
					pend_q[idx_q]    <= 1'b0;
					run_q[idx_q]     <= 1'b1;
				end
				mcrt_pkg::OP_PEND: begin
					pend_q[idx_q] <= 1'b0;
				end
				mcrt_pkg::OP_TICK_ADD: begin
					if (run_q[idx_q]) begin
						if (ge) begin
							active_q[idx_q] <= cur_shadow;
							pend_q[idx_q]   <= 1'b1;
						end else begin
							elapsed_q[idx_q] <= sum[TW-1:0];
						end
					end
				end
				mcrt_pkg::OP_SETTLE: begin
					elapsed_q[idx_q] <= (cur_active == '0) ? '0 : acc_q;
				end
				mcrt_pkg::OP_MOD_WRITE: begin
					elapsed_q[idx_q] <= div_rem;
				end
				default: begin
				end
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mcrt_pkg::OP_CAPTURE) begin
			func_q      <= in_func;
			sel_q       <= in_timer_sel;
			pre_q       <= in_prescale;
			per_q       <= in_period_value;
			res_count_q <= '0;
			res_pend_q  <= 1'b0;
		end
		if (cmd.op == mcrt_pkg::OP_MUL) begin
			prod_q <= prod_full[TW-1:0];
		end
		if (cmd.op == mcrt_pkg::OP_TICK_ADD) begin
			acc_q <= diff[TW-1:0];
		end
		if (cmd.op == mcrt_pkg::OP_PEND) begin
			res_pend_q <= pend_q[idx_q];
		end
		if (cmd.op == mcrt_pkg::OP_CNT_WRITE) begin
			res_count_q <= div_quo[mcrt_pkg::COUNT_W-1:0];
		end
		if (cmd.out_load) begin
			out_count_q <= res_count_q;
			out_pend_q  <= res_pend_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_count_value  = out_count_q;
	assign out_pending_flag = out_pend_q;

endmodule

// File: src/mcrt_ctrl.sv
// Sequencer: decodes a request and steps the datapath through it.
module mcrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcrt_pkg::dp_sts_t   sts,
	output mcrt_pkg::dp_cmd_t   cmd
);

	mcrt_pkg::state_t state_q;
	mcrt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = mcrt_pkg::OP_NONE;
		cmd.idx_clr  = 1'b0;
		cmd.idx_inc  = 1'b0;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			mcrt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = mcrt_pkg::OP_CAPTURE;
					state_d = mcrt_pkg::S_DECODE;
				end
			end
			mcrt_pkg::S_DECODE: begin
				state_d = mcrt_pkg::S_FINISH;
				if (sts.func == mcrt_pkg::FN_TICK) begin
					cmd.idx_clr = 1'b1;
					state_d     = mcrt_pkg::S_TADD;
				end else if (sts.sel_ok) begin
					case (sts.func)
						mcrt_pkg::FN_INIT, mcrt_pkg::FN_SET_PERIOD: begin
							cmd.op  = mcrt_pkg::OP_MUL;
							state_d = mcrt_pkg::S_WRITE;
						end
						mcrt_pkg::FN_START: begin
							cmd.op = mcrt_pkg::OP_START;
						end
						mcrt_pkg::FN_READ_COUNT: begin
							cmd.op  = mcrt_pkg::OP_CNT_START;
							state_d = mcrt_pkg::S_CWAIT;
						end
						mcrt_pkg::FN_READ_PEND: begin
							cmd.op = mcrt_pkg::OP_PEND;
						end
						default: begin
						end
					endcase
				end
			end
			mcrt_pkg::S_WRITE: begin
				cmd.op  = (sts.func == mcrt_pkg::FN_INIT) ? mcrt_pkg::OP_INIT
				                                          : mcrt_pkg::OP_SHADOW;
				state_d = mcrt_pkg::S_FINISH;
			end
			mcrt_pkg::S_TADD: begin
				cmd.op = mcrt_pkg::OP_TICK_ADD;
				if (sts.running && sts.expire) begin
					state_d = mcrt_pkg::S_TSETTLE;
				end else if (sts.idx_last) begin
					state_d = mcrt_pkg::S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			mcrt_pkg::S_TSETTLE: begin
				if (sts.zero_per || sts.rem_lt) begin
					cmd.op = mcrt_pkg::OP_SETTLE;
					if (sts.idx_last) begin
						state_d = mcrt_pkg::S_FINISH;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = mcrt_pkg::S_TADD;
					end
				end else begin
					cmd.op  = mcrt_pkg::OP_MOD_START;
					state_d = mcrt_pkg::S_TDIV;
				end
			end
			mcrt_pkg::S_TDIV: begin
				if (sts.div_done) begin
					cmd.op = mcrt_pkg::OP_MOD_WRITE;
					if (sts.idx_last) begin
						state_d = mcrt_pkg::S_FINISH;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = mcrt_pkg::S_TADD;
					end
				end
			end
			mcrt_pkg::S_CWAIT: begin
				if (sts.div_done) begin
					cmd.op  = mcrt_pkg::OP_CNT_WRITE;
					state_d = mcrt_pkg::S_FINISH;
				end
			end
			mcrt_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mcrt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mcrt_pkg::S_IDLE;
			end
		endcase
	end

	a_done_when_waiting : assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == mcrt_pkg::S_TDIV || state_q == mcrt_pkg::S_CWAIT))
		else $error("divider finished outside a wait state");

	a_load_needs_room : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken beat");

	a_no_index_wrap : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idx_inc |-> !sts.idx_last)
		else $error("timer index stepped past the last timer");

	a_one_load_per_request : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == mcrt_pkg::S_IDLE)
		else $error("sequencer did not return to idle after a result");

endmodule

// File: src/multi_channel_reload_timer_top.sv
// Top level of the multi-channel auto-reload timer bank.
// A bank of NUM_TIMERS up-counting timers kept in fine clock units. Each request beat on in_ch
// carries one operation: tick (add tick_step to every running timer and handle expiries), init,
// set shadow period, start, read count (elapsed divided by the timer's divider) or read-and-clear
// pending. Every request gives exactly one result beat on out_ch; fields that do not apply read 0.
// The block works on one request at a time, driven by a sequencer over a single shared datapath.
// Start and read pending go from acceptance through decode to the result register; init and
// set period also pass through the period-scaling multiplier, and read count waits for the
// quotient from the one-bit-per-cycle divider. A tick walks the timers in index order, one per
// cycle while none expires; an expiry adds a settle step when the remainder is already below
// the new period (or the new period is zero), or else a reduction of the remainder modulo the
// new period through the same divider; acceptance, decode and result load come on top. The
// next request is taken in the cycle after the result is loaded, even if out_ch has not yet taken
// that beat, since the output register holds it. tick_step is written through cfg_wr_en /
// cfg_wr_data and resets to 1000; write it only while no request is in flight.
module multi_channel_reload_timer_top #(
	parameter int NUM_TIMERS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mcrt_pkg::STEP_W-1:0]  cfg_wr_data,
	mcrt_in_if.sink                      in_ch,
	mcrt_out_if.source                   out_ch
);

	// command and status between sequencer and datapath
	mcrt_pkg::dp_cmd_t cmd;
	mcrt_pkg::dp_sts_t sts;

	// Sequencer: accepts a request beat only when idle, then steps the datapath.
	mcrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: timer state, multiplier, divider and the output register.
	mcrt_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_func          (in_ch.func),
		.in_timer_sel     (in_ch.timer_sel),
		.in_prescale      (in_ch.prescale),
		.in_period_value  (in_ch.period_value),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_count_value  (out_ch.count_value),
		.out_pending_flag (out_ch.pending_flag)
	);

endmodule
